[sv/lc3x_pkg.sv]
// ---------------------------------------------------------------------------
// lc3x_pkg
// Shared types and constants for the LC-3 executor.
// ---------------------------------------------------------------------------
package lc3x_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam logic [15:0] START_PC_RST  = 16'h3000;
  localparam logic [2:0]  FLAG_MASK     = 3'h7;
  localparam int unsigned OPC_LSB       = 12;

  localparam logic [2:0] ACT_WR    = 3'd0;
  localparam logic [2:0] ACT_RD    = 3'd1;
  localparam logic [2:0] ACT_RST   = 3'd2;
  localparam logic [2:0] ACT_EXEC  = 3'd3;
  localparam logic [2:0] ACT_CHAR  = 3'd4;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_TRAP   = 2'd1;
  localparam logic [1:0] ST_ILL    = 2'd2;
  localparam logic [1:0] ST_PRIV   = 2'd3;

  localparam logic [3:0] OP_BR  = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_LD  = 4'd2;
  localparam logic [3:0] OP_ST  = 4'd3;
  localparam logic [3:0] OP_JSR = 4'd4;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_LDR = 4'd6;
  localparam logic [3:0] OP_STR = 4'd7;
  localparam logic [3:0] OP_RTI = 4'd8;
  localparam logic [3:0] OP_NOT = 4'd9;
  localparam logic [3:0] OP_LDI = 4'd10;
  localparam logic [3:0] OP_STI = 4'd11;
  localparam logic [3:0] OP_JMP = 4'd12;
  localparam logic [3:0] OP_RSV = 4'd13;
  localparam logic [3:0] OP_LEA = 4'd14;
  localparam logic [3:0] OP_TRP = 4'd15;

  // memory port request from the sequencer
  typedef struct packed {
    logic        en;
    logic        we;
    logic [15:0] addr;
    logic [15:0] wdata;
  } mem_req_t;

  function automatic logic [2:0] nzp(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'h0000) f = 3'b010;
    else if (v[15])    f = 3'b100;
    else               f = 3'b001;
    return f;
  endfunction

endpackage

[sv/lc3_instruction_executor.sv]
// ---------------------------------------------------------------------------
// lc3_instruction_executor
// LC-3 core with local word memory, driven one host request at a time.
// ---------------------------------------------------------------------------
// Host write, restart and char go straight to the result state, host read
// waits for its data, and execute does a fetch plus up to two data accesses
// on the one RAM port. Requests are taken one at a time, only when idle.
// A result waits in the output register while the next request is taken.
// Reset (synchronous, rst_n low): registers zero, PC = start_pc reset value,
// flags and mode zero; memory contents are undefined until written.
module lc3_instruction_executor #(
  parameter int unsigned ADDR_BITS = lc3x_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_mem_address,
  input  logic [15:0] in_mem_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_trap_vector,
  output logic [15:0] out_read_data,
  output logic [15:0] out_next_pc,
  output logic [2:0]  out_cond_flags,
  output logic [15:0] out_r0_value
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,  // instruction word arrives
    S_MEM1  = 7'b0000100,  // first data word arrives
    S_MEM2  = 7'b0001000,  // second data word arrives
    S_HRD   = 7'b0010000,  // host read data arrives
    S_WAIT  = 7'b0100000,  // store issued, settle
    S_DONE  = 7'b1000000   // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] start_pc_r;
  logic [15:0] regs_r [8];
  logic [15:0] pc_r, psr_r;
  logic [15:0] ir_r;
  logic [1:0]  stat_r;
  logic [15:0] rd_r;

  logic        ov_r;
  logic [1:0]  o_stat_r;
  logic [7:0]  o_vec_r;
  logic [15:0] o_rd_r, o_pc_r, o_r0_r;
  logic [2:0]  o_cc_r;

  lc3x_pkg::mem_req_t req;
  logic [15:0]        mrd;

  lc3x_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (.clk(clk), .req(req), .rdata(mrd));

  // Accept only when idle; the output register frees the core from the sink.
  assign in_stall = (state_r != S_IDLE);
  wire acc = in_valid && !in_stall;

  // decode of the latched instruction (or the one arriving from memory)
  logic [15:0] ins;
  assign ins = (state_r == S_FETCH) ? mrd : ir_r;
  logic [3:0]  opc;
  logic [2:0]  dr, sr1;
  logic [15:0] bop, off9, off11, off6;
  logic [15:0] pc_inc;
  assign opc   = ins[15:lc3x_pkg::OPC_LSB];
  assign dr    = ins[11:9];
  assign sr1   = ins[8:6];
  assign off9  = {{7{ins[8]}}, ins[8:0]};
  assign off11 = {{5{ins[10]}}, ins[10:0]};
  assign off6  = {{10{ins[5]}}, ins[5:0]};
  assign bop   = ins[5] ? {{11{ins[4]}}, ins[4:0]} : regs_r[ins[2:0]];
  // PC-relative forms use the PC already advanced past the instruction
  assign pc_inc = pc_r + 16'd1;

  logic        done_go;
  logic        rf_we, cc_we;
  logic [2:0]  rf_a;
  logic [15:0] rf_d;

  always_comb begin
    state_nxt = state_r;
    req       = '0;
    rf_we     = 1'b0;
    cc_we     = 1'b0;
    rf_a      = dr;
    rf_d      = '0;
    done_go   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_action)
            lc3x_pkg::ACT_WR: begin
              req = '{en: 1'b1, we: 1'b1, addr: in_mem_address, wdata: in_mem_data};
              state_nxt = S_DONE;
            end
            lc3x_pkg::ACT_RD: begin
              req = '{en: 1'b1, we: 1'b0, addr: in_mem_address, wdata: 16'h0};
              state_nxt = S_HRD;
            end
            lc3x_pkg::ACT_EXEC: begin
              req = '{en: 1'b1, we: 1'b0, addr: pc_r, wdata: 16'h0};
              state_nxt = S_FETCH;
            end
            lc3x_pkg::ACT_CHAR: begin
              rf_we = 1'b1; cc_we = 1'b1; rf_a = 3'd0; rf_d = in_mem_data;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;  // restart handled in the clocked block
          endcase
        end
      end
      S_HRD: state_nxt = S_DONE;
      S_FETCH: begin
        state_nxt = S_DONE;
        case (opc)
          lc3x_pkg::OP_ADD: begin
            rf_we = 1'b1; cc_we = 1'b1; rf_d = regs_r[sr1] + bop;
          end
          lc3x_pkg::OP_AND: begin
            rf_we = 1'b1; cc_we = 1'b1; rf_d = regs_r[sr1] & bop;
          end
          lc3x_pkg::OP_NOT: begin
            rf_we = 1'b1; cc_we = 1'b1; rf_d = ~regs_r[sr1];
          end
          lc3x_pkg::OP_LEA: begin
            rf_we = 1'b1; cc_we = 1'b1; rf_d = pc_inc + off9;
          end
          lc3x_pkg::OP_JSR: begin
            rf_we = 1'b1; rf_a = 3'd7; rf_d = pc_inc;
          end
          lc3x_pkg::OP_LD, lc3x_pkg::OP_LDI, lc3x_pkg::OP_STI: begin
            req = '{en: 1'b1, we: 1'b0, addr: pc_inc + off9, wdata: 16'h0};
            state_nxt = S_MEM1;
          end
          lc3x_pkg::OP_LDR: begin
            req = '{en: 1'b1, we: 1'b0, addr: regs_r[sr1] + off6, wdata: 16'h0};
            state_nxt = S_MEM1;
          end
          lc3x_pkg::OP_ST: begin
            req = '{en: 1'b1, we: 1'b1, addr: pc_inc + off9, wdata: regs_r[dr]};
            state_nxt = S_WAIT;
          end
          lc3x_pkg::OP_STR: begin
            req = '{en: 1'b1, we: 1'b1, addr: regs_r[sr1] + off6, wdata: regs_r[dr]};
            state_nxt = S_WAIT;
          end
          lc3x_pkg::OP_RTI: begin
            if (!psr_r[15]) begin
              req = '{en: 1'b1, we: 1'b0, addr: regs_r[6], wdata: 16'h0};
              state_nxt = S_MEM1;
            end
          end
          default: ;
        endcase
      end
      S_MEM1: begin
        state_nxt = S_DONE;
        case (opc)
          lc3x_pkg::OP_LD, lc3x_pkg::OP_LDR: begin
            rf_we = 1'b1; cc_we = 1'b1; rf_d = mrd;
          end
          lc3x_pkg::OP_LDI: begin
            req = '{en: 1'b1, we: 1'b0, addr: mrd, wdata: 16'h0};
            state_nxt = S_MEM2;
          end
          lc3x_pkg::OP_STI: begin
            req = '{en: 1'b1, we: 1'b1, addr: mrd, wdata: regs_r[dr]};
            state_nxt = S_WAIT;
          end
          lc3x_pkg::OP_RTI: begin
            // PC pop taken in the clocked block; read the saved status word
            req = '{en: 1'b1, we: 1'b0, addr: regs_r[6] + 16'd1, wdata: 16'h0};
            rf_we = 1'b1; rf_a = 3'd6; rf_d = regs_r[6] + 16'd1;
            state_nxt = S_MEM2;
          end
          default: ;
        endcase
      end
      S_MEM2: begin
        state_nxt = S_DONE;
        if (opc == lc3x_pkg::OP_LDI) begin
          rf_we = 1'b1; cc_we = 1'b1; rf_d = mrd;
        end else begin
          rf_we = 1'b1; rf_a = 3'd6; rf_d = regs_r[6] + 16'd1;
        end
      end
      S_WAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          done_go   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      start_pc_r <= lc3x_pkg::START_PC_RST;
      pc_r       <= lc3x_pkg::START_PC_RST;
      psr_r      <= '0;
      ov_r       <= 1'b0;
      stat_r     <= lc3x_pkg::ST_DONE;
      for (int i = 0; i < 8; i++) regs_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) start_pc_r <= cfg_wdata;
      if (rf_we) regs_r[rf_a] <= rf_d;
      if (cc_we) psr_r[2:0] <= lc3x_pkg::nzp(rf_d);
      if (acc) begin
        stat_r <= lc3x_pkg::ST_DONE;
        rd_r   <= '0;
        if (in_action == lc3x_pkg::ACT_RST) begin
          pc_r       <= start_pc_r;
          psr_r[2:0] <= 3'b000;
        end
      end
      if (state_r == S_HRD) rd_r <= mrd;
      if (state_r == S_FETCH) begin
        ir_r <= mrd;
        // advance past the instruction, or redirect where needed
        case (opc)
          lc3x_pkg::OP_BR:
            pc_r <= ((dr & psr_r[2:0]) != 3'b000) ? (pc_inc + off9) : pc_inc;
          lc3x_pkg::OP_JSR:
            pc_r <= ins[11] ? (pc_inc + off11) : regs_r[sr1];
          lc3x_pkg::OP_JMP: pc_r <= regs_r[sr1];
          lc3x_pkg::OP_TRP: begin
            pc_r   <= pc_inc;
            stat_r <= lc3x_pkg::ST_TRAP;
          end
          lc3x_pkg::OP_RTI: begin
            pc_r <= pc_inc;
            if (psr_r[15]) stat_r <= lc3x_pkg::ST_PRIV;
          end
          lc3x_pkg::OP_RSV: begin
            pc_r   <= pc_inc;
            stat_r <= lc3x_pkg::ST_ILL;
          end
          default: pc_r <= pc_inc;
        endcase
      end
      if (state_r == S_MEM1 && opc == lc3x_pkg::OP_RTI) pc_r <= mrd;
      if (state_r == S_MEM2 && opc == lc3x_pkg::OP_RTI) psr_r <= mrd;
      if (done_go) begin
        ov_r     <= 1'b1;
        o_stat_r <= stat_r;
        o_vec_r  <= (stat_r == lc3x_pkg::ST_TRAP) ? ir_r[7:0] : 8'h00;
        o_rd_r   <= rd_r;
        o_pc_r   <= pc_r;
        o_cc_r   <= psr_r[2:0];
        o_r0_r   <= regs_r[0];
      end else if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = o_stat_r;
  assign out_trap_vector = o_vec_r;
  assign out_read_data   = o_rd_r;
  assign out_next_pc     = o_pc_r;
  assign out_cond_flags  = o_cc_r;
  assign out_r0_value    = o_r0_r;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |=> (state_r != S_IDLE)) else $error("fetch skipped result");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    done_go |=> out_valid) else $error("result lost");
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
`endif

endmodule

[sv/lc3x_mem.sv]
// ---------------------------------------------------------------------------
// lc3x_mem
// Single-port synchronous word memory with a registered read.
// ---------------------------------------------------------------------------
module lc3x_mem #(
  parameter int unsigned ADDR_BITS = lc3x_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  lc3x_pkg::mem_req_t  req,
  output logic [15:0]         rdata
);

  logic [15:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
      end else begin
        rdata <= mem[req.addr[ADDR_BITS-1:0]];
      end
    end
  end

endmodule
